>>> rtl/aamcr_pkg.sv
// Shared types, constants and box-overlap helper for the collision resolver.
package aamcr_pkg;

   // Word kinds on the request tuser field.
   typedef enum logic [1:0] {
      CMD_FRAME    = 2'd0,
      CMD_SOLID    = 2'd1,
      CMD_FREE     = 2'd2,
      CMD_OBSTACLE = 2'd3
   } cmd_type;

   typedef logic signed [23:0] step_type;   // Q16.8 step
   typedef logic signed [25:0] box_type;    // Q18.8 box edge
   typedef logic signed [26:0] coord_type;  // box edge plus step

   // Speed multiplier: floor(delta * 256000 / 16666) saturated to 5.0 (Q3.8).
   localparam logic [10:0] MultMax  = 11'd1280;
   localparam longint unsigned MultNum = 64'd128000;
   localparam longint unsigned MultDen = 64'd8333;
   localparam int unsigned RecipShift = 24;
   // Rounded-up reciprocal; error stays far below 1/MultDen for small deltas.
   localparam logic [27:0] MultRecip =
      28'(((64'd1 << RecipShift) * MultNum) / MultDen + 64'd1);
   // Smallest delta whose quotient exceeds MultMax.
   localparam logic [31:0] DeltaSat =
      32'(((64'd1281 * 64'd16666) + 64'd255999) / 64'd256000);

   typedef struct packed {
      cmd_type           cmd;
      logic [31:0]       time_now;
      logic [15:0]       entity_id;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [19:0]       ext_left;
      logic [19:0]       ext_right;
      logic [19:0]       ext_top;
      logic [19:0]       ext_bottom;
      logic signed [15:0] speed_x;
      logic signed [15:0] speed_y;
      logic              last;
   } req_item_type;

   // Closed-interval overlap; touching edges count.
   function automatic logic overlap(input coord_type ax0, input coord_type ax1,
                                    input coord_type ay0, input coord_type ay1,
                                    input coord_type bx0, input coord_type bx1,
                                    input coord_type by0, input coord_type by1);
      return !((ax0 > bx1) || (bx0 > ax1) || (ay0 > by1) || (by0 > ay1));
   endfunction

endpackage

>>> rtl/aamcr_in_reg.sv
// Input register: captures one request word and holds it until consumed.
module aamcr_in_reg
   import aamcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [207:0]  req_tdata,
   input  logic [1:0]    req_tuser,
   input  logic          req_tlast,
   input  logic          item_take,
   output logic          item_valid,
   output req_item_type  item
);

   logic         in_valid_ff, in_valid_in;
   req_item_type item_ff, item_in;

   assign req_tready = !in_valid_ff || item_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_comb begin
      item_in.cmd        = cmd_type'(req_tuser);
      item_in.time_now   = req_tdata[31:0];
      item_in.entity_id  = req_tdata[47:32];
      item_in.pos_x      = req_tdata[71:48];
      item_in.pos_y      = req_tdata[95:72];
      item_in.ext_left   = req_tdata[115:96];
      item_in.ext_right  = req_tdata[135:116];
      item_in.ext_top    = req_tdata[155:136];
      item_in.ext_bottom = req_tdata[175:156];
      item_in.speed_x    = req_tdata[191:176];
      item_in.speed_y    = req_tdata[207:192];
      item_in.last       = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = in_valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/aamcr_speed.sv
// Frame timer: tracks previous frame time and forms the Q3.8 speed multiplier.
module aamcr_speed
   import aamcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        frame_fire,
   input  logic [31:0] time_now,
   output logic [10:0] speed_mult
);

   logic        have_prev_ff, have_prev_in;
   logic [31:0] prev_time_ff, prev_time_in;
   logic [10:0] speed_mult_ff, speed_mult_in;
   logic [31:0] delta;
   logic [34:0] scaled;

   assign delta  = have_prev_ff ? (time_now - prev_time_ff) : 32'd0;
   // Only deltas below DeltaSat reach the product, so 7 bits suffice.
   assign scaled = {28'd0, delta[6:0]} * {7'd0, MultRecip};

   always_comb begin
      have_prev_in  = have_prev_ff;
      prev_time_in  = prev_time_ff;
      speed_mult_in = speed_mult_ff;
      if (frame_fire) begin
         have_prev_in = 1'b1;
         prev_time_in = time_now;
         if (delta >= DeltaSat) begin
            speed_mult_in = MultMax;
         end else begin
            speed_mult_in = scaled[34:24];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         prev_time_ff  <= 32'd0;
         speed_mult_ff <= 11'd0;
      end else begin
         have_prev_ff  <= have_prev_in;
         prev_time_ff  <= prev_time_in;
         speed_mult_ff <= speed_mult_in;
      end
   end

   assign speed_mult = speed_mult_ff;

endmodule

>>> rtl/aamcr_resolve.sv
// Mover state, obstacle test with axis slide, and the result register.
module aamcr_resolve
   import aamcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  req_item_type  item,
   input  logic [10:0]   speed_mult,
   output logic          item_take,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [47:0]   rsp_tdata,
   output logic          rsp_tuser,
   output logic          rsp_tlast
);

   // mover state
   logic [15:0] mover_id_ff, mover_id_in;
   box_type     mx0_ff, mx1_ff, my0_ff, my1_ff;
   box_type     mx0_in, mx1_in, my0_in, my1_in;
   step_type    dx_ff, dy_ff, ax_ff, ay_ff;
   step_type    dx_in, dy_in, ax_in, ay_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_hit_ff, rsp_hit_in;
   logic     rsp_done_ff, rsp_done_in;
   step_type rsp_sx_ff, rsp_sx_in, rsp_sy_ff, rsp_sy_in;

   coord_type bx0, bx1, by0, by1;
   coord_type x0, x1, y0, y1;
   coord_type dx, dy, ax, ay;
   logic [27:0] prod_x, prod_y;
   step_type    step_x, step_y;
   logic hit_full, hit_allowed, ovl_keep_x, ovl_keep_y, self_hit;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_tready);

   // item box
   assign bx0 = {{3{item.pos_x[23]}}, item.pos_x} - $signed({7'd0, item.ext_left});
   assign bx1 = {{3{item.pos_x[23]}}, item.pos_x} + $signed({7'd0, item.ext_right});
   assign by0 = {{3{item.pos_y[23]}}, item.pos_y} - $signed({7'd0, item.ext_top});
   assign by1 = {{3{item.pos_y[23]}}, item.pos_y} + $signed({7'd0, item.ext_bottom});

   // desired step: floor(speed * mult / 256)
   assign prod_x = {{12{item.speed_x[15]}}, item.speed_x} * {17'd0, speed_mult};
   assign prod_y = {{12{item.speed_y[15]}}, item.speed_y} * {17'd0, speed_mult};
   assign step_x = {{4{prod_x[27]}}, prod_x[27:8]};
   assign step_y = {{4{prod_y[27]}}, prod_y[27:8]};

   assign x0 = {mx0_ff[25], mx0_ff};
   assign x1 = {mx1_ff[25], mx1_ff};
   assign y0 = {my0_ff[25], my0_ff};
   assign y1 = {my1_ff[25], my1_ff};
   assign dx = {{3{dx_ff[23]}}, dx_ff};
   assign dy = {{3{dy_ff[23]}}, dy_ff};
   assign ax = {{3{ax_ff[23]}}, ax_ff};
   assign ay = {{3{ay_ff[23]}}, ay_ff};

   assign self_hit    = (item.entity_id == mover_id_ff);
   assign hit_full    = overlap(x0 + dx, x1 + dx, y0 + dy, y1 + dy, bx0, bx1, by0, by1);
   assign hit_allowed = overlap(x0 + ax, x1 + ax, y0 + ay, y1 + ay, bx0, bx1, by0, by1);
   // still blocked with x step removed / with y step removed
   assign ovl_keep_x  = overlap(x0, x1, y0 + ay, y1 + ay, bx0, bx1, by0, by1);
   assign ovl_keep_y  = overlap(x0 + ax, x1 + ax, y0, y1, bx0, bx1, by0, by1);

   always_comb begin
      mover_id_in  = mover_id_ff;
      mx0_in       = mx0_ff;
      mx1_in       = mx1_ff;
      my0_in       = my0_ff;
      my1_in       = my1_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_sx_in    = rsp_sx_ff;
      rsp_sy_in    = rsp_sy_ff;
      if (item_take) begin
         unique case (item.cmd)
            CMD_FRAME: begin
               rsp_valid_in = 1'b0;
            end
            CMD_SOLID, CMD_FREE: begin
               mover_id_in  = item.entity_id;
               mx0_in       = bx0[25:0];
               mx1_in       = bx1[25:0];
               my0_in       = by0[25:0];
               my1_in       = by1[25:0];
               dx_in        = step_x;
               dy_in        = step_y;
               ax_in        = step_x;
               ay_in        = step_y;
               rsp_valid_in = (item.cmd == CMD_FREE);
               rsp_hit_in   = 1'b0;
               rsp_done_in  = 1'b1;
               rsp_sx_in    = step_x;
               rsp_sy_in    = step_y;
            end
            CMD_OBSTACLE: begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = !self_hit && hit_full;
               rsp_done_in  = item.last;
               rsp_sx_in    = ax_ff;
               rsp_sy_in    = ay_ff;
               if (!self_hit && hit_full && hit_allowed) begin
                  priority if (!ovl_keep_x) begin
                     ax_in = '0;
                  end else if (!ovl_keep_y) begin
                     ay_in = '0;
                  end else begin
                     ax_in = '0;
                     ay_in = '0;
                  end
               end
               rsp_sx_in = ax_in;
               rsp_sy_in = ay_in;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mover_id_ff  <= 16'd0;
         mx0_ff       <= '0;
         mx1_ff       <= '0;
         my0_ff       <= '0;
         my1_ff       <= '0;
         dx_ff        <= '0;
         dy_ff        <= '0;
         ax_ff        <= '0;
         ay_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mover_id_ff  <= mover_id_in;
         mx0_ff       <= mx0_in;
         mx1_ff       <= mx1_in;
         my0_ff       <= my0_in;
         my1_ff       <= my1_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         ax_ff        <= ax_in;
         ay_ff        <= ay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff  <= rsp_hit_in;
      rsp_done_ff <= rsp_done_in;
      rsp_sx_ff   <= rsp_sx_in;
      rsp_sy_ff   <= rsp_sy_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_sy_ff, rsp_sx_ff};
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

>>> rtl/aabb_move_collision_resolver_top.sv
// A result word leaves once its request word has passed the input register,
// then the result register.
// Throughput: one request word per cycle unless rsp_tready holds it, set by the test
// between the input and result registers; frame and solid-mover words give no result.
// Reset (synchronous, active high) clears frame timing, multiplier and mover state to zero.
// Top level of the axis-slide collision resolver.
module aabb_move_collision_resolver_top
   import aamcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // request stream
   input  logic          req_tvalid,
   output logic          req_tready,
   // from bit 0: time_now[32], entity_id[16], pos_x[24], pos_y[24],
   // ext_left[20], ext_right[20], ext_top[20], ext_bottom[20],
   // speed_x[16], speed_y[16]
   input  logic [207:0]  req_tdata,
   input  logic [1:0]    req_tuser,   // cmd: frame, solid mover, free mover, obstacle
   input  logic          req_tlast,   // last obstacle for this mover
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [47:0]   rsp_tdata,   // from bit 0: step_x[24], step_y[24]
   output logic          rsp_tuser,   // hit
   output logic          rsp_tlast    // done_res
);

   req_item_type item;
   logic         item_valid;
   logic         item_take;
   logic [10:0]  speed_mult;

   // Request word is held here until the resolve stage can take it.
   aamcr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item       (item)
   );

   // Frame words update the multiplier; the next mover word sees it.
   aamcr_speed u_speed (
      .clock      (clock),
      .reset      (reset),
      .frame_fire (item_take && (item.cmd == CMD_FRAME)),
      .time_now   (item.time_now),
      .speed_mult (speed_mult)
   );

   // Mover load, obstacle test and slide, result register.
   aamcr_resolve u_resolve (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .speed_mult (speed_mult),
      .item_take  (item_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
